>>> hdl/tgp_pkg.sv
// Shared types, constants and helpers for the touch gesture to pointer block.
package tgp_pkg;

  localparam int COORD_BITS     = 16;
  localparam int TIME_BITS      = 63;
  localparam int CNT_BITS       = 4;
  localparam int SLOP_BITS      = 12;
  localparam int TMO_BITS       = 32;
  localparam int STEP_BITS      = 12;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_IDX_BITS   = 2;
  localparam int RESID_BITS     = 18;
  localparam int MAG_BITS       = 18;
  localparam int RUN_BITS       = 7;
  localparam int DIV_CNT_BITS   = $clog2(MAG_BITS + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam int DEF_MAX_WHEEL_RUN = 64;
  localparam int DEF_MAX_FINGERS   = 10;

  localparam logic [SLOP_BITS-1:0] SLOP_RESET    = 12'd224;
  localparam logic [TMO_BITS-1:0]  TIMEOUT_RESET = 32'd400000000;
  localparam logic [STEP_BITS-1:0] STEP_RESET    = 12'd512;
  localparam logic [STEP_BITS-1:0] STEP_MIN      = 12'd16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_SLOP    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WHEEL_STEP  = 2'd2;

  localparam logic signed [7:0] WHEEL_DOWN = -8'sd120;
  localparam logic signed [7:0] WHEEL_UP   = 8'sd120;
  localparam logic signed [7:0] WHEEL_NONE = 8'sd0;

  localparam logic [RUN_BITS-1:0] RUN_ONE = 7'd1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_DOWN   = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_UP     = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PENDING = 2'd1,
    MODE_DRAG    = 2'd2,
    MODE_TWO     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_WHEEL   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_LEFT  = 2'd1,
    BTN_RIGHT = 2'd2
  } btn_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQX,
    F_SQY,
    F_DEC,
    F_DIV,
    F_PUSH
  } fstate_t;

  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    kind_t                kind;
    btn_t                 button;
    coord_t               x;
    coord_t               y;
    logic signed [7:0]    delta;
    logic [RUN_BITS-1:0]  rep;
    logic                 last;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [MAG_BITS-1:0]  dividend;
    logic [STEP_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [MAG_BITS-1:0]  quot;
    logic [STEP_BITS-1:0] remd;
  } div_rsp_t;

  function automatic entry_t mk_entry(kind_t kind, btn_t button, coord_t x, coord_t y,
                                      logic signed [7:0] delta, logic [RUN_BITS-1:0] rep,
                                      logic last);
    entry_t e;
    e.kind   = kind;
    e.button = button;
    e.x      = x;
    e.y      = y;
    e.delta  = delta;
    e.rep    = rep;
    e.last   = last;
    return e;
  endfunction

endpackage

>>> hdl/tgp_if.sv
// Valid/ready channel interfaces for touch events and pointer results.
interface tgp_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cmd;
  logic [tgp_pkg::COORD_BITS-1:0]    touch_x;
  logic [tgp_pkg::COORD_BITS-1:0]    touch_y;
  logic [tgp_pkg::CNT_BITS-1:0]      pressed_count;
  logic [tgp_pkg::TIME_BITS-1:0]     time_ns;

  modport source(output valid, cmd, touch_x, touch_y, pressed_count, time_ns, input ready);
  modport sink(input valid, cmd, touch_x, touch_y, pressed_count, time_ns, output ready);
endinterface

interface tgp_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        out_kind;
  logic [1:0]                        button;
  logic [tgp_pkg::COORD_BITS-1:0]    out_x;
  logic [tgp_pkg::COORD_BITS-1:0]    out_y;
  logic signed [7:0]                 wheel_delta;
  logic                              last;

  modport source(output valid, out_kind, button, out_x, out_y, wheel_delta, last, input ready);
  modport sink(input valid, out_kind, button, out_x, out_y, wheel_delta, last, output ready);
endinterface

>>> hdl/tgp_div.sv
// Restoring divider, one quotient bit per cycle, for wheel step counting.
module tgp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tgp_pkg::div_req_t req,
  output tgp_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [tgp_pkg::DIV_CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [tgp_pkg::STEP_BITS-1:0]     rem_r, rem_nxt;
  logic [tgp_pkg::STEP_BITS-1:0]     d_r, d_nxt;
  logic [tgp_pkg::MAG_BITS-1:0]      q_r, q_nxt;
  logic [tgp_pkg::STEP_BITS:0]       sh;
  logic                              qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    sh       = {rem_r, q_r[tgp_pkg::MAG_BITS-1]};
    qbit     = (sh >= {1'b0, d_r});
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tgp_pkg::DIV_CNT_BITS'(tgp_pkg::MAG_BITS);
      rem_nxt  = '0;
      d_nxt    = req.divisor;
      q_nxt    = req.dividend;
    end else if (busy_r) begin
      rem_nxt = qbit ? tgp_pkg::STEP_BITS'(sh - {1'b0, d_r}) : sh[tgp_pkg::STEP_BITS-1:0];
      q_nxt   = {q_r[tgp_pkg::MAG_BITS-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tgp_pkg::DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.remd = rem_r;

endmodule

>>> hdl/tgp_front.sv
// Front end: accepts touch events, tracks gesture state, queues result entries.
module tgp_front #(
  parameter int MAX_WHEEL_RUN = tgp_pkg::DEF_MAX_WHEEL_RUN,
  parameter int MAX_FINGERS   = tgp_pkg::DEF_MAX_FINGERS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tgp_pkg::cfg_wr_t  cfg,
  tgp_in_if.sink            in_ch,
  output logic              q_push,
  output tgp_pkg::entry_t   q_wdata,
  input  logic              q_full
);

  localparam int LIST_DEPTH = 3;

  tgp_pkg::fstate_t                  state_r, state_nxt;
  tgp_pkg::mode_t                    mode_r, mode_nxt;
  tgp_pkg::coord_t                   press_x_r, press_x_nxt;
  tgp_pkg::coord_t                   press_y_r, press_y_nxt;
  tgp_pkg::coord_t                   prev_x_r, prev_x_nxt;
  tgp_pkg::coord_t                   prev_y_r, prev_y_nxt;
  logic [tgp_pkg::TIME_BITS-1:0]     press_time_r, press_time_nxt;
  logic signed [tgp_pkg::RESID_BITS-1:0] resid_r, resid_nxt;
  logic                              scrolled_r, scrolled_nxt;

  logic [tgp_pkg::SLOP_BITS-1:0]     slop_r;
  logic [tgp_pkg::TMO_BITS-1:0]      timeout_r;
  logic [tgp_pkg::STEP_BITS-1:0]     wstep_r;
  logic [2*tgp_pkg::SLOP_BITS-1:0]   slop_sq_r;

  tgp_pkg::cmd_t                     ev_cmd_r;
  tgp_pkg::coord_t                   ev_x_r, ev_y_r;
  logic [tgp_pkg::CNT_BITS-1:0]      ev_cnt_r;
  logic [tgp_pkg::TIME_BITS-1:0]     ev_t_r;

  logic [2*tgp_pkg::COORD_BITS-1:0]  sqx_r, sqx_nxt, sqy_r, sqy_nxt, sq;
  logic                              neg_r, neg_nxt;
  logic                              pos_r, pos_nxt;

  tgp_pkg::entry_t                   lst_r [LIST_DEPTH];
  tgp_pkg::entry_t                   lst_nxt [LIST_DEPTH];
  logic [1:0]                        lst_n_r, lst_n_nxt;

  tgp_pkg::div_req_t                 div_req;
  tgp_pkg::div_rsp_t                 div_rsp;

  logic [tgp_pkg::COORD_BITS:0]      dx, dy, ndx, ndy;
  tgp_pkg::coord_t                   adx, ady, mul_a;
  logic [2*tgp_pkg::COORD_BITS:0]    d2;
  logic [tgp_pkg::CNT_BITS-1:0]      cnt_c;
  logic                              two_plus, no_finger;
  logic [tgp_pkg::TIME_BITS-1:0]     elapsed;
  logic                              quick;
  logic signed [tgp_pkg::MAG_BITS:0] r_s, nr_s;
  logic [tgp_pkg::MAG_BITS-1:0]      mag;
  logic [tgp_pkg::STEP_BITS-1:0]     wstep_eff;
  logic [tgp_pkg::RUN_BITS-1:0]      steps;
  logic signed [7:0]                 wdelta;
  logic signed [tgp_pkg::RESID_BITS-1:0] rem_s;

  tgp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_ch.ready = (state_r == tgp_pkg::F_IDLE);

  assign dx    = {1'b0, ev_x_r} - {1'b0, press_x_r};
  assign dy    = {1'b0, ev_y_r} - {1'b0, press_y_r};
  assign ndx   = -dx;
  assign ndy   = -dy;
  assign adx   = dx[tgp_pkg::COORD_BITS] ? ndx[tgp_pkg::COORD_BITS-1:0]
                                         : dx[tgp_pkg::COORD_BITS-1:0];
  assign ady   = dy[tgp_pkg::COORD_BITS] ? ndy[tgp_pkg::COORD_BITS-1:0]
                                         : dy[tgp_pkg::COORD_BITS-1:0];
  assign mul_a = (state_r == tgp_pkg::F_SQX) ? adx : ady;
  assign sq    = {{tgp_pkg::COORD_BITS{1'b0}}, mul_a} * {{tgp_pkg::COORD_BITS{1'b0}}, mul_a};
  assign d2    = {1'b0, sqx_r} + {1'b0, sqy_r};

  assign cnt_c     = ({1'b0, ev_cnt_r} > (tgp_pkg::CNT_BITS + 1)'(MAX_FINGERS))
                     ? tgp_pkg::CNT_BITS'(MAX_FINGERS) : ev_cnt_r;
  assign two_plus  = (cnt_c >= tgp_pkg::CNT_BITS'(2));
  assign no_finger = (cnt_c == '0);

  assign elapsed = ev_t_r - press_time_r;
  assign quick   = elapsed[tgp_pkg::TIME_BITS-1]
                   || (elapsed < {{(tgp_pkg::TIME_BITS-tgp_pkg::TMO_BITS){1'b0}}, timeout_r});

  assign r_s  = (tgp_pkg::MAG_BITS + 1)'(resid_r)
                + $signed({3'b000, ev_y_r}) - $signed({3'b000, prev_y_r});
  assign nr_s = -r_s;
  assign mag  = r_s[tgp_pkg::MAG_BITS] ? nr_s[tgp_pkg::MAG_BITS-1:0]
                                       : r_s[tgp_pkg::MAG_BITS-1:0];
  assign wstep_eff = (wstep_r < tgp_pkg::STEP_MIN) ? tgp_pkg::STEP_MIN : wstep_r;

  assign steps  = (div_rsp.quot > tgp_pkg::MAG_BITS'(MAX_WHEEL_RUN))
                  ? tgp_pkg::RUN_BITS'(MAX_WHEEL_RUN) : div_rsp.quot[tgp_pkg::RUN_BITS-1:0];
  assign wdelta = pos_r ? tgp_pkg::WHEEL_DOWN : tgp_pkg::WHEEL_UP;
  assign rem_s  = $signed({{(tgp_pkg::RESID_BITS-tgp_pkg::STEP_BITS){1'b0}}, div_rsp.remd});

  assign q_wdata = lst_r[0];

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    press_x_nxt    = press_x_r;
    press_y_nxt    = press_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    press_time_nxt = press_time_r;
    resid_nxt      = resid_r;
    scrolled_nxt   = scrolled_r;
    sqx_nxt        = sqx_r;
    sqy_nxt        = sqy_r;
    neg_nxt        = neg_r;
    pos_nxt        = pos_r;
    lst_nxt        = lst_r;
    lst_n_nxt      = lst_n_r;
    div_req        = '0;
    q_push         = 1'b0;
    unique case (state_r)
      tgp_pkg::F_IDLE: begin
        if (in_ch.valid) state_nxt = tgp_pkg::F_SQX;
      end
      tgp_pkg::F_SQX: begin
        sqx_nxt   = sq;
        state_nxt = tgp_pkg::F_SQY;
      end
      tgp_pkg::F_SQY: begin
        sqy_nxt   = sq;
        state_nxt = tgp_pkg::F_DEC;
      end
      tgp_pkg::F_DEC: begin
        lst_n_nxt = 2'd0;
        case (ev_cmd_r)
          tgp_pkg::CMD_DOWN: begin
            if (mode_r == tgp_pkg::MODE_IDLE) begin
              mode_nxt       = tgp_pkg::MODE_PENDING;
              press_x_nxt    = ev_x_r;
              press_y_nxt    = ev_y_r;
              prev_x_nxt     = ev_x_r;
              prev_y_nxt     = ev_y_r;
              press_time_nxt = ev_t_r;
              scrolled_nxt   = 1'b0;
            end else if (mode_r == tgp_pkg::MODE_PENDING && two_plus) begin
              mode_nxt     = tgp_pkg::MODE_TWO;
              resid_nxt    = '0;
              scrolled_nxt = 1'b0;
            end else if (mode_r == tgp_pkg::MODE_DRAG && two_plus) begin
              lst_nxt[0]   = tgp_pkg::mk_entry(tgp_pkg::KIND_RELEASE, tgp_pkg::BTN_LEFT,
                               prev_x_r, prev_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE, 1'b1);
              lst_n_nxt    = 2'd1;
              mode_nxt     = tgp_pkg::MODE_TWO;
              resid_nxt    = '0;
              scrolled_nxt = 1'b0;
            end
          end
          tgp_pkg::CMD_MOVE: begin
            prev_x_nxt = ev_x_r;
            prev_y_nxt = ev_y_r;
            if (mode_r == tgp_pkg::MODE_PENDING) begin
              if (d2 > {{(2*tgp_pkg::COORD_BITS+1-2*tgp_pkg::SLOP_BITS){1'b0}}, slop_sq_r})
              begin
                lst_nxt[0] = tgp_pkg::mk_entry(tgp_pkg::KIND_MOVE, tgp_pkg::BTN_NONE,
                               press_x_r, press_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE,
                               1'b0);
                lst_nxt[1] = tgp_pkg::mk_entry(tgp_pkg::KIND_PRESS, tgp_pkg::BTN_LEFT,
                               press_x_r, press_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE,
                               1'b0);
                lst_nxt[2] = tgp_pkg::mk_entry(tgp_pkg::KIND_MOVE, tgp_pkg::BTN_NONE,
                               ev_x_r, ev_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE, 1'b1);
                lst_n_nxt  = 2'd3;
                mode_nxt   = tgp_pkg::MODE_DRAG;
              end
            end else if (mode_r == tgp_pkg::MODE_DRAG) begin
              lst_nxt[0] = tgp_pkg::mk_entry(tgp_pkg::KIND_MOVE, tgp_pkg::BTN_NONE,
                             ev_x_r, ev_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE, 1'b1);
              lst_n_nxt  = 2'd1;
            end else if (mode_r == tgp_pkg::MODE_TWO) begin
              div_req.start    = 1'b1;
              div_req.dividend = mag;
              div_req.divisor  = wstep_eff;
              neg_nxt          = r_s < 0;
              pos_nxt          = r_s > 0;
            end
          end
          tgp_pkg::CMD_UP: begin
            if (mode_r == tgp_pkg::MODE_PENDING
                || (mode_r == tgp_pkg::MODE_TWO && no_finger && !scrolled_r && quick)) begin
              lst_nxt[0] = tgp_pkg::mk_entry(tgp_pkg::KIND_MOVE, tgp_pkg::BTN_NONE,
                             press_x_r, press_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE,
                             1'b0);
              lst_nxt[1] = tgp_pkg::mk_entry(tgp_pkg::KIND_PRESS,
                             (mode_r == tgp_pkg::MODE_PENDING) ? tgp_pkg::BTN_LEFT
                                                               : tgp_pkg::BTN_RIGHT,
                             press_x_r, press_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE,
                             1'b0);
              lst_nxt[2] = tgp_pkg::mk_entry(tgp_pkg::KIND_RELEASE,
                             (mode_r == tgp_pkg::MODE_PENDING) ? tgp_pkg::BTN_LEFT
                                                               : tgp_pkg::BTN_RIGHT,
                             press_x_r, press_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE,
                             1'b1);
              lst_n_nxt  = 2'd3;
            end else if (mode_r == tgp_pkg::MODE_DRAG && no_finger) begin
              lst_nxt[0] = tgp_pkg::mk_entry(tgp_pkg::KIND_MOVE, tgp_pkg::BTN_NONE,
                             ev_x_r, ev_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE, 1'b0);
              lst_nxt[1] = tgp_pkg::mk_entry(tgp_pkg::KIND_RELEASE, tgp_pkg::BTN_LEFT,
                             ev_x_r, ev_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE, 1'b1);
              lst_n_nxt  = 2'd2;
            end
            if (mode_r == tgp_pkg::MODE_PENDING
                || ((mode_r == tgp_pkg::MODE_DRAG || mode_r == tgp_pkg::MODE_TWO)
                    && no_finger)) begin
              mode_nxt = tgp_pkg::MODE_IDLE;
            end
          end
          default: begin
            if (mode_r == tgp_pkg::MODE_DRAG) begin
              lst_nxt[0] = tgp_pkg::mk_entry(tgp_pkg::KIND_RELEASE, tgp_pkg::BTN_LEFT,
                             prev_x_r, prev_y_r, tgp_pkg::WHEEL_NONE, tgp_pkg::RUN_ONE, 1'b1);
              lst_n_nxt  = 2'd1;
            end
            mode_nxt     = tgp_pkg::MODE_IDLE;
            resid_nxt    = '0;
            scrolled_nxt = 1'b0;
          end
        endcase
        if (ev_cmd_r == tgp_pkg::CMD_MOVE && mode_r == tgp_pkg::MODE_TWO) begin
          state_nxt = tgp_pkg::F_DIV;
        end else if (lst_n_nxt != 2'd0) begin
          state_nxt = tgp_pkg::F_PUSH;
        end else begin
          state_nxt = tgp_pkg::F_IDLE;
        end
      end
      tgp_pkg::F_DIV: begin
        if (div_rsp.done) begin
          resid_nxt = neg_r ? -rem_s : rem_s;
          if (steps != '0) begin
            lst_nxt[0]   = tgp_pkg::mk_entry(tgp_pkg::KIND_WHEEL, tgp_pkg::BTN_NONE,
                             ev_x_r, ev_y_r, wdelta, steps, 1'b1);
            lst_n_nxt    = 2'd1;
            scrolled_nxt = 1'b1;
            state_nxt    = tgp_pkg::F_PUSH;
          end else begin
            state_nxt = tgp_pkg::F_IDLE;
          end
        end
      end
      tgp_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          lst_nxt[0] = lst_r[1];
          lst_nxt[1] = lst_r[2];
          lst_n_nxt  = lst_n_r - 2'd1;
          if (lst_n_r == 2'd1) state_nxt = tgp_pkg::F_IDLE;
        end
      end
      default: state_nxt = tgp_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tgp_pkg::F_IDLE;
      mode_r       <= tgp_pkg::MODE_IDLE;
      press_x_r    <= '0;
      press_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      press_time_r <= '0;
      resid_r      <= '0;
      scrolled_r   <= 1'b0;
      lst_n_r      <= 2'd0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      press_x_r    <= press_x_nxt;
      press_y_r    <= press_y_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      press_time_r <= press_time_nxt;
      resid_r      <= resid_nxt;
      scrolled_r   <= scrolled_nxt;
      lst_n_r      <= lst_n_nxt;
    end
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    neg_r   <= neg_nxt;
    pos_r   <= pos_nxt;
    lst_r   <= lst_nxt;
    slop_sq_r <= {{tgp_pkg::SLOP_BITS{1'b0}}, slop_r} * {{tgp_pkg::SLOP_BITS{1'b0}}, slop_r};
    if (in_ch.valid && in_ch.ready) begin
      ev_cmd_r <= tgp_pkg::cmd_t'(in_ch.cmd);
      ev_x_r   <= in_ch.touch_x;
      ev_y_r   <= in_ch.touch_y;
      ev_cnt_r <= in_ch.pressed_count;
      ev_t_r   <= in_ch.time_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slop_r    <= tgp_pkg::SLOP_RESET;
      timeout_r <= tgp_pkg::TIMEOUT_RESET;
      wstep_r   <= tgp_pkg::STEP_RESET;
    end else if (cfg.we) begin
      if (cfg.index == tgp_pkg::CFG_TAP_SLOP) slop_r <= cfg.data[tgp_pkg::SLOP_BITS-1:0];
      if (cfg.index == tgp_pkg::CFG_TAP_TIMEOUT) timeout_r <= cfg.data;
      if (cfg.index == tgp_pkg::CFG_WHEEL_STEP) wstep_r <= cfg.data[tgp_pkg::STEP_BITS-1:0];
    end
  end

endmodule

>>> hdl/tgp_queue.sv
// Small FIFO of result entries between the front end and the back end.
module tgp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tgp_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output tgp_pkg::entry_t rdata,
  output logic            empty
);

  tgp_pkg::entry_t                 mem [tgp_pkg::QUEUE_DEPTH];
  logic [tgp_pkg::QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tgp_pkg::QCNT_BITS-1:0]   count_r;

  assign full  = (count_r == tgp_pkg::QCNT_BITS'(tgp_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> hdl/tgp_back.sv
// Back end: expands queued entries into result transactions through an output register.
module tgp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tgp_pkg::entry_t q_rdata,
  input  logic            q_empty,
  output logic            q_pop,
  tgp_out_if.source       out_ch
);

  tgp_pkg::entry_t                 cur_r;
  logic                            cur_v_r;
  logic [tgp_pkg::RUN_BITS-1:0]    rem_r;
  logic                            out_v_r;
  tgp_pkg::entry_t                 out_r, out_nxt;
  logic                            load;
  logic                            final_rep;

  assign load      = cur_v_r && (!out_v_r || out_ch.ready);
  assign final_rep = (rem_r == tgp_pkg::RUN_ONE);
  assign q_pop     = !q_empty && (!cur_v_r || (load && final_rep));

  always_comb begin
    out_nxt      = cur_r;
    out_nxt.last = cur_r.last && final_rep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) cur_v_r <= 1'b1;
      else if (load && final_rep) cur_v_r <= 1'b0;
      if (load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
    if (q_pop) begin
      cur_r <= q_rdata;
      rem_r <= q_rdata.rep;
    end else if (load) begin
      rem_r <= rem_r - 1'b1;
    end
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_kind    = out_r.kind;
  assign out_ch.button      = out_r.button;
  assign out_ch.out_x       = out_r.x;
  assign out_ch.out_y       = out_r.y;
  assign out_ch.wheel_delta = out_r.delta;
  assign out_ch.last        = out_r.last;

endmodule

>>> hdl/touch_gesture_to_pointer.sv
// Top level of the touch gesture to pointer mapper. An event passes the front end states SQX,
// SQY, DEC and PUSH, the queue, and the back end entry and output registers; a two-finger move
// adds the bit-serial wheel step division in DIV (one quotient bit a cycle). The front end takes
// no new event until it has pushed every entry (up to 3) of the last one, and a wheel run leaves
// at one result per cycle while the receiver is ready. Reset (rst_n low, synchronous) restores
// idle mode, zero positions and residual, and the default registers; there is no clearing pass.
module touch_gesture_to_pointer #(
  parameter int MAX_WHEEL_RUN = tgp_pkg::DEF_MAX_WHEEL_RUN,
  parameter int MAX_FINGERS   = tgp_pkg::DEF_MAX_FINGERS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tgp_in_if.sink                               in_ch,
  tgp_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [tgp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [tgp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  tgp_pkg::cfg_wr_t cfg;
  logic             q_push, q_full, q_pop, q_empty;
  tgp_pkg::entry_t  q_wdata, q_rdata;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tgp_front #(
    .MAX_WHEEL_RUN(MAX_WHEEL_RUN),
    .MAX_FINGERS  (MAX_FINGERS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_wdata(q_wdata),
    .q_full (q_full)
  );

  tgp_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  tgp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rdata(q_rdata),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for touch_gesture_to_pointer: directed and random touch gestures, scoreboarded.
module tb_top;
  import tgp_pkg::*;

  localparam int MAX_RUN   = DEF_MAX_WHEEL_RUN;
  localparam int MAX_FING  = DEF_MAX_FINGERS;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    cmd_t                 cmd;
    coord_t               x;
    coord_t               y;
    logic [CNT_BITS-1:0]  fingers;
    logic [TIME_BITS-1:0] stamp;
  } touch_t;

  typedef struct {
    kind_t             kind;
    btn_t              button;
    coord_t            x;
    coord_t            y;
    logic signed [7:0] delta;
    logic              last;
  } pointer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  tgp_in_if  in_ch();
  tgp_out_if out_ch();

  touch_gesture_to_pointer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // gesture tracker state
  logic [SLOP_BITS-1:0] slop_r    = SLOP_RESET;
  logic [TMO_BITS-1:0]  timeout_r = TIMEOUT_RESET;
  logic [STEP_BITS-1:0] step_r    = STEP_RESET;
  mode_t                gmode     = MODE_IDLE;
  coord_t               press_x   = '0;
  coord_t               press_y   = '0;
  coord_t               prev_x    = '0;
  coord_t               prev_y    = '0;
  logic [TIME_BITS-1:0] press_t   = '0;
  longint               residual  = 0;
  logic                 scrolled  = 1'b0;

  touch_t   touch_q[$];
  pointer_t pointer_q[$];
  touch_t   on_wire;
  pointer_t want;
  logic     took;
  logic     calm = 1'b0;
  logic     hold_ready = 1'b0;
  int       src_gap = 0;
  int       sink_stall = 0;
  int       accepted_events = 0;
  int       queued_events = 0;
  int       mismatches = 0;
  logic [TIME_BITS-1:0] clock_ns = '0;
  coord_t   cur_x, cur_y;

  task automatic emit(kind_t k, btn_t b, coord_t x, coord_t y, logic signed [7:0] d,
                      inout int n);
    pointer_t r;
    r.kind   = k;
    r.button = b;
    r.x      = x;
    r.y      = y;
    r.delta  = d;
    r.last   = 1'b0;
    pointer_q.push_back(r);
    n++;
  endtask

  task automatic click(btn_t b, inout int n);
    emit(KIND_MOVE, BTN_NONE, press_x, press_y, WHEEL_NONE, n);
    emit(KIND_PRESS, b, press_x, press_y, WHEEL_NONE, n);
    emit(KIND_RELEASE, b, press_x, press_y, WHEEL_NONE, n);
  endtask

  task automatic predict_touch(input touch_t ev);
    longint dx, dy, stride, travel, mag, steps;
    logic [TIME_BITS-1:0] held;
    logic [CNT_BITS-1:0] fingers;
    logic signed [7:0] notch;
    pointer_t tail;
    int n;
    n = 0;
    fingers = (ev.fingers > MAX_FING) ? CNT_BITS'(MAX_FING) : ev.fingers;
    case (ev.cmd)
      CMD_DOWN: begin
        if (gmode == MODE_IDLE) begin
          gmode = MODE_PENDING;
          press_x = ev.x;
          press_y = ev.y;
          prev_x = ev.x;
          prev_y = ev.y;
          press_t = ev.stamp;
          scrolled = 1'b0;
        end else if (fingers >= 2 && (gmode == MODE_PENDING || gmode == MODE_DRAG)) begin
          if (gmode == MODE_DRAG) emit(KIND_RELEASE, BTN_LEFT, prev_x, prev_y, WHEEL_NONE, n);
          gmode = MODE_TWO;
          residual = 0;
          scrolled = 1'b0;
        end
      end
      CMD_MOVE: begin
        if (gmode == MODE_PENDING) begin
          dx = longint'(ev.x) - longint'(press_x);
          dy = longint'(ev.y) - longint'(press_y);
          if (dx * dx + dy * dy > longint'(slop_r) * longint'(slop_r)) begin
            emit(KIND_MOVE, BTN_NONE, press_x, press_y, WHEEL_NONE, n);
            emit(KIND_PRESS, BTN_LEFT, press_x, press_y, WHEEL_NONE, n);
            emit(KIND_MOVE, BTN_NONE, ev.x, ev.y, WHEEL_NONE, n);
            gmode = MODE_DRAG;
          end
        end else if (gmode == MODE_DRAG) begin
          emit(KIND_MOVE, BTN_NONE, ev.x, ev.y, WHEEL_NONE, n);
        end else if (gmode == MODE_TWO) begin
          stride = (step_r < STEP_MIN) ? longint'(STEP_MIN) : longint'(step_r);
          travel = residual + (longint'(ev.y) - longint'(prev_y));
          mag = (travel < 0) ? -travel : travel;
          steps = mag / stride;
          notch = (travel > 0) ? WHEEL_DOWN : WHEEL_UP;
          if (steps > MAX_RUN) steps = MAX_RUN;
          for (longint k = 0; k < steps; k++) emit(KIND_WHEEL, BTN_NONE, ev.x, ev.y, notch, n);
          if (steps > 0) scrolled = 1'b1;
          residual = (travel < 0) ? -(mag % stride) : (mag % stride);
        end
        prev_x = ev.x;
        prev_y = ev.y;
      end
      CMD_UP: begin
        if (gmode == MODE_PENDING) begin
          click(BTN_LEFT, n);
          gmode = MODE_IDLE;
        end else if (gmode == MODE_DRAG && fingers == 0) begin
          emit(KIND_MOVE, BTN_NONE, ev.x, ev.y, WHEEL_NONE, n);
          emit(KIND_RELEASE, BTN_LEFT, ev.x, ev.y, WHEEL_NONE, n);
          gmode = MODE_IDLE;
        end else if (gmode == MODE_TWO && fingers == 0) begin
          held = ev.stamp - press_t;
          if (!scrolled && (held[TIME_BITS-1] || held < timeout_r)) click(BTN_RIGHT, n);
          gmode = MODE_IDLE;
        end
      end
      default: begin
        if (gmode == MODE_DRAG) emit(KIND_RELEASE, BTN_LEFT, prev_x, prev_y, WHEEL_NONE, n);
        gmode = MODE_IDLE;
        residual = 0;
        scrolled = 1'b0;
      end
    endcase
    if (n > 0) begin
      tail = pointer_q.pop_back();
      tail.last = 1'b1;
      pointer_q.push_back(tail);
    end
  endtask

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // event driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        predict_touch(on_wire);
        accepted_events++;
      end
      if (!in_ch.valid || took) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (touch_q.size() > 0) begin
          on_wire = touch_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.cmd           <= on_wire.cmd;
          in_ch.touch_x       <= on_wire.x;
          in_ch.touch_y       <= on_wire.y;
          in_ch.pressed_count <= on_wire.fingers;
          in_ch.time_ns       <= on_wire.stamp;
          if (!calm && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 12);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pointer_q.size() == 0) begin
          $display("%0t unexpected transaction: expected none actual kind %0d x %0d y %0d",
                   $time, out_ch.out_kind, out_ch.out_x, out_ch.out_y);
          mismatches++;
        end else begin
          want = pointer_q.pop_front();
          check_field("out_kind", want.kind, out_ch.out_kind);
          check_field("button", want.button, out_ch.button);
          check_field("out_x", want.x, out_ch.out_x);
          check_field("out_y", want.y, out_ch.out_y);
          check_field("wheel_delta", want.delta, out_ch.wheel_delta);
          check_field("last", want.last, out_ch.last);
        end
      end
      if (sink_stall > 0) sink_stall--;
      else if (!calm && $urandom_range(0, 15) == 0) sink_stall = $urandom_range(1, 12);
      out_ch.ready <= !hold_ready && sink_stall == 0;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (accepted_events >= 80);
    @(posedge clk);
    hold_ready <= 1'b1;
    repeat (300) @(posedge clk);
    hold_ready <= 1'b0;
  end

  initial begin
    #10000000;
    $display("touch_gesture_to_pointer verification failed");
    $finish;
  end

  function automatic coord_t nudge(coord_t base, int span);
    int pos;
    pos = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (pos < 0) pos = 0;
    else if (pos > COORD_MAX) pos = COORD_MAX;
    return coord_t'(pos);
  endfunction

  task automatic push_touch(cmd_t c, coord_t x, coord_t y, logic [CNT_BITS-1:0] fingers);
    touch_t ev;
    ev.cmd     = c;
    ev.x       = x;
    ev.y       = y;
    ev.fingers = fingers;
    ev.stamp   = clock_ns;
    touch_q.push_back(ev);
    queued_events++;
    clock_ns = clock_ns + TIME_BITS'($urandom_range(1, 20000000));
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_TAP_SLOP:    slop_r = value[SLOP_BITS-1:0];
      CFG_TAP_TIMEOUT: timeout_r = value[TMO_BITS-1:0];
      CFG_WHEEL_STEP:  step_r = value[STEP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [SLOP_BITS-1:0] slop, logic [TMO_BITS-1:0] tmo,
                          logic [STEP_BITS-1:0] step);
    write_reg(CFG_TAP_SLOP, {20'($urandom), slop});
    write_reg(CFG_TAP_TIMEOUT, tmo);
    write_reg(CFG_WHEEL_STEP, {20'($urandom), step});
    write_reg(CFG_SPARE, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (touch_q.size() != 0 || in_ch.valid || pointer_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_gesture();
    int shape, span;
    shape = $urandom_range(0, 9);
    cur_x = coord_t'($urandom);
    cur_y = coord_t'($urandom);
    if ($urandom_range(0, 7) == 0) clock_ns = TIME_BITS'({$urandom, $urandom});
    if (shape >= 8) begin
      repeat ($urandom_range(1, 4))
        push_touch(cmd_t'($urandom_range(0, 3)), coord_t'($urandom), coord_t'($urandom),
                   CNT_BITS'($urandom));
    end else begin
      push_touch(CMD_DOWN, cur_x, cur_y, 4'd1);
      if (shape < 2) begin
        repeat ($urandom_range(0, 2)) begin
          cur_x = nudge(cur_x, 16);
          cur_y = nudge(cur_y, 16);
          push_touch(CMD_MOVE, cur_x, cur_y, 4'd1);
        end
        push_touch(CMD_UP, cur_x, cur_y, CNT_BITS'($urandom_range(0, 1)));
      end else if (shape < 4) begin
        repeat ($urandom_range(1, 5)) begin
          cur_x = nudge(cur_x, 600);
          cur_y = nudge(cur_y, 600);
          push_touch(CMD_MOVE, cur_x, cur_y, 4'd1);
        end
        if ($urandom_range(0, 2) == 0)
          push_touch(CMD_UP, cur_x, cur_y, CNT_BITS'($urandom_range(1, 9)));
        if ($urandom_range(0, 4) == 0) push_touch(CMD_CANCEL, cur_x, cur_y, 4'd0);
        else push_touch(CMD_UP, nudge(cur_x, 40), nudge(cur_y, 40), 4'd0);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          cur_x = nudge(cur_x, 600);
          cur_y = nudge(cur_y, 600);
          push_touch(CMD_MOVE, cur_x, cur_y, 4'd1);
        end
        push_touch(CMD_DOWN, cur_x, cur_y, CNT_BITS'($urandom_range(2, 15)));
        case ($urandom_range(0, 3))
          0: span = 8;
          1: span = 300;
          2: span = 3000;
          default: span = COORD_MAX;
        endcase
        repeat ($urandom_range(0, 6)) begin
          cur_x = nudge(cur_x, 64);
          cur_y = nudge(cur_y, span);
          push_touch(CMD_MOVE, cur_x, cur_y, 4'd2);
        end
        if ($urandom_range(0, 1) == 0)
          push_touch(CMD_UP, cur_x, cur_y, CNT_BITS'($urandom_range(1, 10)));
        if ($urandom_range(0, 2) == 0) clock_ns = clock_ns + TIME_BITS'($urandom);
        else if ($urandom_range(0, 9) == 0)
          clock_ns = clock_ns - TIME_BITS'($urandom_range(1, 30000000));
        if ($urandom_range(0, 5) == 0) push_touch(CMD_CANCEL, cur_x, cur_y, 4'd0);
        else push_touch(CMD_UP, cur_x, cur_y, 4'd0);
      end
    end
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = queued_events + count;
    while (queued_events < stop_at) random_gesture();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.touch_x = '0;
    in_ch.touch_y = '0;
    in_ch.pressed_count = '0;
    in_ch.time_ns = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    set_regs(SLOP_RESET, TIMEOUT_RESET, STEP_RESET);
    // tap at the origin, lifted with an out-of-range finger count; then a move in idle
    push_touch(CMD_DOWN, 16'h0000, 16'h0000, 4'd1);
    push_touch(CMD_UP, 16'h0007, 16'h0007, 4'd15);
    push_touch(CMD_MOVE, 16'h1234, 16'h4321, 4'd0);
    // drag from the far corner: inside slop, beyond slop, up with fingers left, full up
    push_touch(CMD_DOWN, 16'hFFFF, 16'hFFFF, 4'd15);
    push_touch(CMD_MOVE, 16'hFFF0, 16'hFFFF, 4'd1);
    push_touch(CMD_MOVE, 16'h0000, 16'h0000, 4'd1);
    push_touch(CMD_UP, 16'h0003, 16'h0003, 4'd1);
    push_touch(CMD_UP, 16'h0000, 16'h000A, 4'd0);
    // two-finger scroll: clipped long run down, then a short run up, no right click
    push_touch(CMD_DOWN, 16'd100, 16'd0, 4'd1);
    push_touch(CMD_DOWN, 16'd100, 16'd0, 4'd3);
    push_touch(CMD_MOVE, 16'd100, 16'hFFFF, 4'd2);
    push_touch(CMD_MOVE, 16'd100, 16'd64000, 4'd2);
    push_touch(CMD_UP, 16'd100, 16'd64000, 4'd0);
    // quick two-finger tap
    push_touch(CMD_DOWN, 16'd5000, 16'd6000, 4'd1);
    push_touch(CMD_DOWN, 16'd5000, 16'd6000, 4'd2);
    push_touch(CMD_MOVE, 16'd5001, 16'd6003, 4'd2);
    push_touch(CMD_UP, 16'd5001, 16'd6003, 4'd0);
    // two-finger tap with time running backward
    clock_ns = 63'h4000_0000_0000_0000;
    push_touch(CMD_DOWN, 16'd300, 16'd400, 4'd1);
    push_touch(CMD_DOWN, 16'd300, 16'd400, 4'd2);
    clock_ns = 63'h3FFF_FFFF_0000_0000;
    push_touch(CMD_UP, 16'd300, 16'd400, 4'd0);
    // drag interrupted by a second finger, then cancel
    push_touch(CMD_DOWN, 16'd8000, 16'd8000, 4'd1);
    push_touch(CMD_MOVE, 16'd9000, 16'd8000, 4'd1);
    push_touch(CMD_DOWN, 16'd9000, 16'd8000, 4'd2);
    push_touch(CMD_CANCEL, 16'd9000, 16'd8000, 4'd2);
    // cancel during a drag
    push_touch(CMD_DOWN, 16'd200, 16'd200, 4'd1);
    push_touch(CMD_MOVE, 16'd200, 16'd900, 4'd1);
    push_touch(CMD_CANCEL, 16'd0, 16'd0, 4'd0);
    wait_drained();

    set_regs('0, '0, '0);
    random_phase(95);
    wait_drained();

    set_regs('1, '1, '1);
    random_phase(95);
    wait_drained();

    set_regs(SLOP_BITS'($urandom), $urandom, STEP_BITS'($urandom_range(16, 700)));
    random_phase(95);
    wait_drained();

    set_regs(SLOP_RESET, TIMEOUT_RESET, STEP_MIN);
    random_phase(95);
    wait_drained();

    calm <= 1'b1;
    set_regs(SLOP_BITS'($urandom_range(0, 300)), TMO_BITS'($urandom_range(0, 800000000)),
             STEP_BITS'($urandom_range(0, 200)));
    random_phase(95);
    wait_drained();

    if (mismatches == 0 && pointer_q.size() == 0)
      $display("touch_gesture_to_pointer verification clean");
    else
      $display("touch_gesture_to_pointer verification failed");
    $finish;
  end

endmodule
